// File: hdl/ilnfa_pkg.sv
// shared types and constants of the next-fit heap allocator
package ilnfa_pkg;

	typedef logic [17:0] addr_t;
	typedef logic [1:0]  status_t;
	typedef logic [31:0] word_t;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam status_t STATUS_DONE = 2'd0;
	localparam status_t STATUS_NULL = 2'd1;
	localparam status_t STATUS_OOM  = 2'd2;

	localparam word_t SIZE_MASK   = 32'hFFFF_FFF8;
	localparam word_t PREV_BIT    = 32'h0000_0002;
	localparam word_t ALLOC_BIT   = 32'h0000_0001;
	localparam word_t MIN_BLOCK   = 32'd16;
	localparam word_t FIRST_BLOCK = 32'd16;
	localparam word_t SMALL_REQ   = 32'd12;
	localparam word_t PROLOGUE    = 32'd11;

endpackage

// File: hdl/ilnfa_req_if.sv
// request channel of the allocator
interface ilnfa_req_if;
	logic                 valid;
	logic                 ready;
	logic                 cmd;
	ilnfa_pkg::addr_t     request_bytes;
	ilnfa_pkg::addr_t     payload_address;

	modport source (output valid, cmd, request_bytes, payload_address, input ready);
	modport sink (input valid, cmd, request_bytes, payload_address, output ready);
endinterface

// File: hdl/ilnfa_rsp_if.sv
// response channel of the allocator
interface ilnfa_rsp_if;
	logic                 valid;
	logic                 ready;
	ilnfa_pkg::addr_t     block_address;
	ilnfa_pkg::status_t   status;

	modport source (output valid, block_address, status, input ready);
	modport sink (input valid, block_address, status, output ready);
endinterface

// File: hdl/ilnfa_ram.sv
// heap word memory, one write port and one registered read port
module ilnfa_ram #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// File: hdl/implicit_list_next_fit_allocator_top.sv
// top level of the next-fit heap allocator with boundary tags
// One item at a time. After reset the block clears the heap memory, one word per cycle, and then
// writes the initial layout, with req.ready low throughout. A free rewrites the header and footer
// of the block, merges it with free neighbours and clears the prev-allocated bit of the block after
// it. An allocate reads one block header per step of the next-fit walk (with an extra step for a
// free block that is too small on the first pass), grows the heap when no block fits, and then
// places the block. A zero-size request answers with a null status. Most steps are a read or a
// write of the heap memory, whose read data is registered; the walk over the headers sets the time of an allocate.
module implicit_list_next_fit_allocator_top #(
	parameter int HEAP_WORDS  = 65536,
	parameter int CHUNK_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	ilnfa_req_if.sink   req,
	ilnfa_rsp_if.source rsp
);
	import ilnfa_pkg::*;

	localparam int AW = $clog2(HEAP_WORDS);
	localparam word_t CHUNK_AL = (32'(CHUNK_BYTES) + 32'd7) & SIZE_MASK;
	localparam logic [32:0] HEAP_BYTES = 33'(HEAP_WORDS) * 33'd4;
	localparam logic [AW:0] STEP_LIM = (AW+1)'(HEAP_WORDS);
	localparam logic [AW-1:0] CLR_LAST = AW'(HEAP_WORDS - 1);

	localparam logic [4:0] ST_CLR    = 5'd0;
	localparam logic [4:0] ST_IDLE   = 5'd1;
	localparam logic [4:0] ST_WR     = 5'd2;
	localparam logic [4:0] ST_F_RD   = 5'd3;
	localparam logic [4:0] ST_F_HD   = 5'd4;
	localparam logic [4:0] ST_M_RD0  = 5'd5;
	localparam logic [4:0] ST_M_RD1  = 5'd6;
	localparam logic [4:0] ST_M_RD2  = 5'd7;
	localparam logic [4:0] ST_M_RD3  = 5'd8;
	localparam logic [4:0] ST_M_EV   = 5'd9;
	localparam logic [4:0] ST_M_RET  = 5'd10;
	localparam logic [4:0] ST_FN_RD  = 5'd11;
	localparam logic [4:0] ST_FN_NB  = 5'd12;
	localparam logic [4:0] ST_FN_W   = 5'd13;
	localparam logic [4:0] ST_S_RD   = 5'd14;
	localparam logic [4:0] ST_S_EV   = 5'd15;
	localparam logic [4:0] ST_S_NX   = 5'd16;
	localparam logic [4:0] ST_G      = 5'd17;
	localparam logic [4:0] ST_P_RD   = 5'd18;
	localparam logic [4:0] ST_P_EV   = 5'd19;
	localparam logic [4:0] ST_P_RD2  = 5'd20;
	localparam logic [4:0] ST_P_EV2  = 5'd21;
	localparam logic [4:0] ST_DONE   = 5'd22;

	localparam logic RET_FREE = 1'b0;
	localparam logic RET_GROW = 1'b1;

	function automatic logic [AW-1:0] wad(input word_t a);
		return a[AW+1:2];
	endfunction

	logic [4:0]    st_q;
	logic [AW-1:0] clr_q;
	word_t         heap_end_q, rover_q, cur_q, start_q, need_q, bp_q, p_q;
	word_t         own_q, prv_q, nxt_q, nsz_q;
	logic          palloc_q, nalloc_q, lflag_q, pass_q, ret_q;
	logic [AW:0]   steps_q;
	word_t         wq_addr_q [5];
	word_t         wq_val_q [5];
	logic [2:0]    wq_n_q, wq_i_q;
	logic [4:0]    wq_next_q;
	addr_t         res_addr_q;
	status_t       res_status_q;
	logic          out_valid_q;
	addr_t         out_addr_q;
	status_t       out_status_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	word_t         wdata, rdata, rsz, req32, need_c, gsz, have_left;
	word_t         t_next, t_prev, t_both;
	logic [32:0]   grow_sum;

	ilnfa_ram #(.DEPTH(HEAP_WORDS), .AW(AW), .DW(32)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		rsz       = rdata & SIZE_MASK;
		req32     = {14'b0, req.request_bytes};
		need_c    = (req32 <= SMALL_REQ) ? MIN_BLOCK
			: 32'd8 + ((req32 - 32'd4 + 32'd7) & SIZE_MASK);
		gsz       = (need_q > 32'(CHUNK_BYTES)) ? need_q : CHUNK_AL;
		grow_sum  = {1'b0, heap_end_q} + {1'b0, gsz};
		have_left = rsz - need_q;
		t_next    = own_q + nsz_q;
		t_prev    = own_q + rsz;
		t_both    = own_q + rsz + nsz_q;
		we        = (st_q == ST_CLR) || (st_q == ST_WR);
		waddr     = (st_q == ST_CLR) ? clr_q : wad(wq_addr_q[wq_i_q]);
		wdata     = (st_q == ST_CLR) ? '0 : wq_val_q[wq_i_q];
		unique case (st_q)
			ST_F_RD:  raddr = wad(p_q - 32'd4);
			ST_M_RD0: raddr = wad(bp_q - 32'd4);
			ST_M_RD1: raddr = wad(bp_q - 32'd8);
			ST_M_RD2: raddr = wad(nxt_q - 32'd4);
			ST_M_RD3: raddr = wad(prv_q - 32'd4);
			ST_FN_RD: raddr = wad(bp_q - 32'd4);
			ST_FN_NB: raddr = wad(bp_q + rsz - 32'd4);
			ST_S_RD:  raddr = wad(cur_q - 32'd4);
			ST_S_EV:  raddr = wad(cur_q + rsz - 32'd4);
			ST_P_RD:  raddr = wad(bp_q - 32'd4);
			ST_P_RD2: raddr = wad(bp_q + own_q - 32'd4);
			default:  raddr = wad(bp_q - 32'd4);
		endcase
	end

	assign req.ready         = (st_q == ST_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.block_address = out_addr_q;
	assign rsp.status        = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLR;
			clr_q       <= '0;
			heap_end_q  <= FIRST_BLOCK + CHUNK_AL;
			rover_q     <= FIRST_BLOCK;
			out_valid_q <= 1'b0;
			wq_n_q      <= '0;
			wq_i_q      <= '0;
			wq_next_q   <= ST_IDLE;
		end else begin
			if (rsp.valid && rsp.ready && st_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						wq_addr_q[0] <= 32'd4;
						wq_val_q[0]  <= PROLOGUE;
						wq_addr_q[1] <= 32'd8;
						wq_val_q[1]  <= PROLOGUE;
						wq_addr_q[2] <= 32'd12;
						wq_val_q[2]  <= CHUNK_AL | PREV_BIT;
						wq_addr_q[3] <= FIRST_BLOCK + CHUNK_AL - 32'd8;
						wq_val_q[3]  <= CHUNK_AL | PREV_BIT;
						wq_addr_q[4] <= FIRST_BLOCK + CHUNK_AL - 32'd4;
						wq_val_q[4]  <= ALLOC_BIT;
						wq_n_q       <= 3'd5;
						wq_i_q       <= '0;
						wq_next_q    <= ST_IDLE;
						st_q         <= ST_WR;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						res_addr_q   <= '0;
						res_status_q <= STATUS_DONE;
						if (req.cmd == CMD_FREE) begin
							p_q  <= {14'b0, req.payload_address};
							st_q <= ST_F_RD;
						end else if (req.request_bytes == '0) begin
							res_status_q <= STATUS_NULL;
							st_q         <= ST_DONE;
						end else begin
							need_q  <= need_c;
							start_q <= rover_q;
							cur_q   <= rover_q;
							steps_q <= '0;
							pass_q  <= 1'b0;
							lflag_q <= 1'b1;
							st_q    <= ST_S_RD;
						end
					end
				end
				ST_WR: begin
					wq_i_q <= wq_i_q + 1'b1;
					if (wq_i_q == wq_n_q - 3'd1) begin
						st_q <= wq_next_q;
					end
				end
				ST_F_RD: st_q <= ST_F_HD;
				ST_F_HD: begin
					wq_addr_q[0] <= p_q - 32'd4;
					wq_val_q[0]  <= rsz | (rdata & PREV_BIT);
					wq_addr_q[1] <= p_q + rsz - 32'd8;
					wq_val_q[1]  <= rsz | (rdata & PREV_BIT);
					wq_n_q       <= 3'd2;
					wq_i_q       <= '0;
					wq_next_q    <= ST_M_RD0;
					bp_q         <= p_q;
					ret_q        <= RET_FREE;
					st_q         <= ST_WR;
				end
				ST_M_RD0: st_q <= ST_M_RD1;
				ST_M_RD1: begin
					own_q    <= rsz;
					palloc_q <= rdata[1];
					nxt_q    <= bp_q + rsz;
					st_q     <= ST_M_RD2;
				end
				ST_M_RD2: begin
					prv_q <= bp_q - rsz;
					st_q  <= ST_M_RD3;
				end
				ST_M_RD3: begin
					nalloc_q <= rdata[0];
					nsz_q    <= rsz;
					st_q     <= ST_M_EV;
				end
				ST_M_EV: begin
					wq_n_q    <= 3'd2;
					wq_i_q    <= '0;
					wq_next_q <= ST_M_RET;
					priority if (palloc_q && nalloc_q) begin
						st_q <= ST_M_RET;
					end else if (palloc_q) begin
						if (nxt_q == rover_q) rover_q <= bp_q;
						wq_addr_q[0] <= bp_q - 32'd4;
						wq_val_q[0]  <= t_next | PREV_BIT;
						wq_addr_q[1] <= bp_q + t_next - 32'd8;
						wq_val_q[1]  <= t_next | PREV_BIT;
						st_q         <= ST_WR;
					end else if (nalloc_q) begin
						wq_addr_q[0] <= bp_q + own_q - 32'd8;
						wq_val_q[0]  <= t_prev | PREV_BIT;
						wq_addr_q[1] <= prv_q - 32'd4;
						wq_val_q[1]  <= t_prev | PREV_BIT;
						bp_q         <= prv_q;
						st_q         <= ST_WR;
					end else begin
						if (nxt_q == rover_q) rover_q <= prv_q;
						wq_addr_q[0] <= prv_q - 32'd4;
						wq_val_q[0]  <= t_both | PREV_BIT;
						wq_addr_q[1] <= nxt_q + nsz_q - 32'd8;
						wq_val_q[1]  <= t_both | PREV_BIT;
						bp_q         <= prv_q;
						st_q         <= ST_WR;
					end
				end
				ST_M_RET: begin
					if (ret_q == RET_FREE) begin
						if (rover_q == p_q) rover_q <= bp_q;
						st_q <= ST_FN_RD;
					end else if (bp_q == '0) begin
						// merged block at offset zero counts as no space
						res_status_q <= STATUS_OOM;
						st_q         <= ST_DONE;
					end else begin
						st_q <= ST_P_RD;
					end
				end
				ST_FN_RD: st_q <= ST_FN_NB;
				ST_FN_NB: begin
					nxt_q <= bp_q + rsz;
					st_q  <= ST_FN_W;
				end
				ST_FN_W: begin
					wq_addr_q[0] <= nxt_q - 32'd4;
					wq_val_q[0]  <= rdata & ~PREV_BIT;
					wq_n_q       <= 3'd1;
					wq_i_q       <= '0;
					wq_next_q    <= ST_DONE;
					st_q         <= ST_WR;
				end
				ST_S_RD: begin
					if (steps_q == STEP_LIM || (pass_q && cur_q == start_q)) begin
						if (!pass_q) begin
							pass_q  <= 1'b1;
							cur_q   <= FIRST_BLOCK;
							steps_q <= '0;
						end else begin
							st_q <= ST_G;
						end
					end else begin
						st_q <= ST_S_EV;
					end
				end
				ST_S_EV: begin
					priority if (rsz == '0) begin
						if (!pass_q) begin
							pass_q  <= 1'b1;
							cur_q   <= FIRST_BLOCK;
							steps_q <= '0;
							st_q    <= ST_S_RD;
						end else begin
							st_q <= ST_G;
						end
					end else if (!rdata[0] && rsz >= need_q) begin
						rover_q <= cur_q;
						bp_q    <= cur_q;
						st_q    <= ST_P_RD;
					end else begin
						cur_q   <= cur_q + rsz;
						steps_q <= steps_q + 1'b1;
						st_q    <= (!rdata[0] && !pass_q) ? ST_S_NX : ST_S_RD;
					end
				end
				ST_S_NX: begin
					if (rsz == '0) lflag_q <= 1'b0;
					st_q <= ST_S_RD;
				end
				ST_G: begin
					if (grow_sum > HEAP_BYTES) begin
						res_status_q <= STATUS_OOM;
						st_q         <= ST_DONE;
					end else begin
						heap_end_q   <= grow_sum[31:0];
						wq_addr_q[0] <= heap_end_q - 32'd4;
						wq_val_q[0]  <= gsz | (lflag_q ? PREV_BIT : '0);
						wq_addr_q[1] <= heap_end_q + gsz - 32'd8;
						wq_val_q[1]  <= gsz | (lflag_q ? PREV_BIT : '0);
						wq_addr_q[2] <= heap_end_q + gsz - 32'd4;
						wq_val_q[2]  <= ALLOC_BIT;
						wq_n_q       <= 3'd3;
						wq_i_q       <= '0;
						wq_next_q    <= ST_M_RD0;
						bp_q         <= heap_end_q;
						ret_q        <= RET_GROW;
						st_q         <= ST_WR;
					end
				end
				ST_P_RD: st_q <= ST_P_EV;
				ST_P_EV: begin
					own_q      <= rsz;
					wq_i_q     <= '0;
					res_addr_q <= bp_q[17:0];
					st_q       <= ST_WR;
					if (have_left < MIN_BLOCK) begin
						wq_addr_q[0] <= bp_q - 32'd4;
						wq_val_q[0]  <= rsz | ALLOC_BIT | PREV_BIT;
						wq_n_q       <= 3'd1;
						wq_next_q    <= ST_P_RD2;
					end else begin
						wq_addr_q[0] <= bp_q + rsz - 32'd8;
						wq_val_q[0]  <= have_left | PREV_BIT;
						wq_addr_q[1] <= bp_q - 32'd4;
						wq_val_q[1]  <= need_q | ALLOC_BIT | PREV_BIT;
						wq_addr_q[2] <= bp_q + need_q - 32'd4;
						wq_val_q[2]  <= have_left | PREV_BIT;
						wq_n_q       <= 3'd3;
						wq_next_q    <= ST_DONE;
					end
				end
				ST_P_RD2: st_q <= ST_P_EV2;
				ST_P_EV2: begin
					wq_addr_q[0] <= bp_q + own_q - 32'd4;
					wq_val_q[0]  <= rdata | PREV_BIT;
					wq_n_q       <= 3'd1;
					wq_i_q       <= '0;
					wq_next_q    <= ST_DONE;
					st_q         <= ST_WR;
				end
				ST_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_addr_q   <= res_addr_q;
						out_status_q <= res_status_q;
						st_q         <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	a_wq_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_WR |-> wq_i_q < wq_n_q)
		else $error("write queue index past fill");

	a_heap_end: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, heap_end_q} <= HEAP_BYTES)
		else $error("heap end beyond memory");

	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != STATUS_DONE |-> rsp.block_address == '0)
		else $error("failed request returned an address");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("second transfer taken while busy");
endmodule
